[sv/mdep_pkg.sv]
// ----------------------------------------------------------------------------
// mdep_pkg
// shared types, constants and helper functions of the mail date parser
// ----------------------------------------------------------------------------
package mdep_pkg;

   localparam int TOKEN_BYTES = 16;
   localparam int LEN_W       = $clog2(TOKEN_BYTES + 2);
   localparam int IDX_W       = $clog2(TOKEN_BYTES);
   localparam int VAL_W       = 17;
   localparam logic [VAL_W-1:0] VAL_CAP = VAL_W'(100000);

   // character codes
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // end kinds in the result
   localparam logic [1:0] END_EOL = 2'd0;
   localparam logic [1:0] END_EOH = 2'd1;
   localparam logic [1:0] END_EOF = 2'd2;

   // parse phases
   localparam logic [2:0] PH_FIRST = 3'd0;
   localparam logic [2:0] PH_DAY   = 3'd1;
   localparam logic [2:0] PH_MONTH = 3'd2;
   localparam logic [2:0] PH_YEAR  = 3'd3;
   localparam logic [2:0] PH_TIME  = 3'd4;
   localparam logic [2:0] PH_ZONE  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_eof;
   } req_type;

   typedef struct packed {
      logic signed [38:0] epoch_seconds;
      logic               date_valid;
      logic [1:0]         end_kind;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       blank;
      logic       close;
      logic       calc1;
      logic       calc2;
      logic       calc3;
      logic       load_out;
      logic [7:0] chr;
      logic [1:0] end_kind;
   } cmd_type;

   typedef struct packed {
      logic line_started;
   } status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [3:0] digit_of(input logic [7:0] c);
      return 4'(c - CH_ZERO);
   endfunction

   function automatic logic [6:0] two_digits(input logic [7:0] a, input logic [7:0] b);
      return 7'(digit_of(a)) * 7'd10 + 7'(digit_of(b));
   endfunction

   // month abbreviation to 1..12, 0 when none
   function automatic logic [3:0] month_of(input logic [23:0] s);
      logic [3:0] m;
      case (s)
         24'("Jan"): m = 4'd1;
         24'("Feb"): m = 4'd2;
         24'("Mar"): m = 4'd3;
         24'("Apr"): m = 4'd4;
         24'("May"): m = 4'd5;
         24'("Jun"): m = 4'd6;
         24'("Jul"): m = 4'd7;
         24'("Aug"): m = 4'd8;
         24'("Sep"): m = 4'd9;
         24'("Oct"): m = 4'd10;
         24'("Nov"): m = 4'd11;
         24'("Dec"): m = 4'd12;
         default:    m = 4'd0;
      endcase
      return m;
   endfunction

   // days before a month in a march-based year
   function automatic logic [8:0] doy_of(input logic [3:0] mp);
      logic [8:0] d;
      case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[sv/mail_date_to_epoch_parser_core.sv]
// ----------------------------------------------------------------------------
// mail_date_to_epoch_parser_core
// streaming mail date header parser giving utc epoch seconds
// ----------------------------------------------------------------------------
// usage:
//   req channel carries raw header bytes one request at a time, with is_eof
//   marking the end of input; rsp channel returns one result per line end,
//   end of header or non-empty end of file
//   each request is accepted in the idle state, then each of its unfolded
//   events (none, one or two) is handled in the event state; an event that
//   closes a value also passes the three calendar steps and the result
//   load, which waits while an earlier result is still unread
//   the controller handles one request at a time and takes no new request
//   until the last event of the current one is through
//   the result register keeps a finished result while the next request is
//   taken; a stalled receiver holds the block only when a second result is
//   ready to be written
//   synchronous reset clears the unfold state, the parse state and the
//   result valid flag; the token buffer needs no clearing
// ----------------------------------------------------------------------------
module mail_date_to_epoch_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdep_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdep_pkg::rsp_type  rsp_data
);
   import mdep_pkg::*;

   cmd_type    cmd;
   status_type status;

   // unfolding and sequencing
   mdep_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // token fields, arithmetic and result register
   mdep_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[sv/mdep_datapath.sv]
// ----------------------------------------------------------------------------
// mdep_datapath
// token buffer, field parsing, epoch arithmetic and result register
// ----------------------------------------------------------------------------
module mdep_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mdep_pkg::cmd_type    cmd,
   output mdep_pkg::status_type status,
   output mdep_pkg::rsp_type    rsp_data
);
   import mdep_pkg::*;

   logic [7:0]       chars_ff [TOKEN_BYTES];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic             alld_ff, alld_in;
   logic [2:0]       phase_ff, phase_in;
   logic [4:0]       day_ff, day_in;
   logic [3:0]       month_ff, month_in;
   logic [13:0]      year_ff, year_in;
   logic [4:0]       hour_ff, hour_in;
   logic [5:0]       min_ff, min_in;
   logic [5:0]       sec_ff, sec_in;
   logic signed [13:0] zone_ff, zone_in;
   logic             failed_ff, failed_in;
   logic             started_ff, started_in;

   logic [13:0]        y_ff, y_in;
   logic [6:0]         q_ff, q_in;
   logic [8:0]         doy_ff, doy_in;
   logic signed [19:0] tod_ff, tod_in;
   logic signed [22:0] days_ff, days_in;
   logic signed [38:0] epoch_ff, epoch_in;
   rsp_type            out_ff;

   // finish-token decode
   logic             fits, num_ok, dow, day_chk;
   logic [6:0]       th, tm, ts, zh, zm;
   logic [3:0]       mon;
   logic [20:0]      acc;
   logic [26:0]      q_prod;
   logic [3:0]       mp;
   logic [13:0]      zmins;

   always_comb begin
      len_in     = len_ff;
      val_in     = val_ff;
      alld_in    = alld_ff;
      phase_in   = phase_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      hour_in    = hour_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      zone_in    = zone_ff;
      failed_in  = failed_ff;
      started_in = started_ff;

      fits    = len_ff <= LEN_W'(TOKEN_BYTES);
      num_ok  = fits && alld_ff && (len_ff != '0);
      dow     = fits && (len_ff == LEN_W'(4)) && (chars_ff[3] == CH_COMMA);
      day_chk = ((phase_ff == PH_FIRST) && !dow) || (phase_ff == PH_DAY);
      th      = two_digits(chars_ff[0], chars_ff[1]);
      tm      = two_digits(chars_ff[3], chars_ff[4]);
      ts      = two_digits(chars_ff[6], chars_ff[7]);
      zh      = two_digits(chars_ff[1], chars_ff[2]);
      zm      = two_digits(chars_ff[3], chars_ff[4]);
      zmins   = 14'(zh) * 14'd60 + 14'(zm);
      mon     = month_of({chars_ff[0], chars_ff[1], chars_ff[2]});
      acc     = 21'(val_ff) * 21'd10 + 21'(digit_of(cmd.chr));

      if (cmd.push) begin
         started_in = 1'b1;
         if (len_ff <= LEN_W'(TOKEN_BYTES))
            len_in = len_ff + LEN_W'(1);
         if (len_ff == '0) begin
            val_in  = VAL_W'(digit_of(cmd.chr));
            alld_in = is_digit(cmd.chr);
         end else begin
            val_in  = (acc > 21'(VAL_CAP)) ? VAL_CAP : VAL_W'(acc);
            alld_in = alld_ff && is_digit(cmd.chr);
         end
      end

      if (cmd.blank)
         started_in = 1'b1;

      if ((cmd.blank || cmd.close) && (len_ff != '0)) begin
         len_in = '0;
         if (!failed_ff && (phase_ff < PH_DONE)) begin
            if (phase_ff == PH_FIRST && dow) begin
               phase_in = PH_DAY;
            end else if (day_chk) begin
               if (num_ok && val_ff >= VAL_W'(1) && val_ff <= VAL_W'(31)) begin
                  day_in   = 5'(val_ff);
                  phase_in = PH_MONTH;
               end else begin
                  failed_in = 1'b1;
               end
            end else begin
               case (phase_ff)
                  PH_MONTH: begin
                     if (fits && len_ff == LEN_W'(3) && mon != 4'd0) begin
                        month_in = mon;
                        phase_in = PH_YEAR;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  PH_YEAR: begin
                     phase_in = PH_TIME;
                     if (num_ok && val_ff >= VAL_W'(1000) && val_ff <= VAL_W'(9999))
                        year_in = 14'(val_ff);
                     else if (num_ok && val_ff >= VAL_W'(1) && val_ff <= VAL_W'(49))
                        year_in = 14'(val_ff) + 14'd2000;
                     else if (num_ok && val_ff >= VAL_W'(50) && val_ff <= VAL_W'(99))
                        year_in = 14'(val_ff) + 14'd1900;
                     else begin
                        failed_in = 1'b1;
                        phase_in  = phase_ff;
                     end
                  end
                  PH_TIME: begin
                     if (fits && len_ff == LEN_W'(8) && chars_ff[2] == CH_COLON
                         && chars_ff[5] == CH_COLON && is_digit(chars_ff[0])
                         && is_digit(chars_ff[1]) && is_digit(chars_ff[3])
                         && is_digit(chars_ff[4]) && is_digit(chars_ff[6])
                         && is_digit(chars_ff[7]) && th <= 7'd24 && tm <= 7'd59
                         && ts <= 7'd61) begin
                        hour_in  = 5'(th);
                        min_in   = 6'(tm);
                        sec_in   = 6'(ts);
                        phase_in = PH_ZONE;
                     end else if (fits && len_ff == LEN_W'(5) && chars_ff[2] == CH_COLON
                         && is_digit(chars_ff[0]) && is_digit(chars_ff[1])
                         && is_digit(chars_ff[3]) && is_digit(chars_ff[4])
                         && th <= 7'd24 && tm <= 7'd59) begin
                        hour_in  = 5'(th);
                        min_in   = 6'(tm);
                        sec_in   = '0;
                        phase_in = PH_ZONE;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_DONE;
                     if (fits && len_ff == LEN_W'(5)
                         && (chars_ff[0] == CH_PLUS || chars_ff[0] == CH_MINUS)) begin
                        if (is_digit(chars_ff[1]) && is_digit(chars_ff[2])
                            && is_digit(chars_ff[3]) && is_digit(chars_ff[4]))
                           zone_in = (chars_ff[0] == CH_PLUS) ? $signed(zmins)
                                                              : -$signed(zmins);
                        else begin
                           failed_in = 1'b1;
                           phase_in  = phase_ff;
                        end
                     end
                  end
               endcase
            end
         end
      end
   end

   // calendar arithmetic, one step per command
   always_comb begin
      y_in   = year_ff - 14'(month_ff <= 4'd2);
      q_prod = 27'(y_in) * 27'd5243;
      q_in   = 7'(q_prod >> 19);
      mp     = (month_ff > 4'd2) ? month_ff - 4'd3 : month_ff + 4'd9;
      doy_in = doy_of(mp);
      tod_in = $signed(20'(hour_ff) * 20'd3600 + 20'(min_ff) * 20'd60 + 20'(sec_ff)
                       - 20'(zone_ff) * 20'd60);
      days_in = $signed(23'(25'(y_ff) * 25'd365 + 25'(y_ff >> 2) - 25'(q_ff)
                            + 25'(q_ff >> 2) + 25'(doy_ff) + 25'(day_ff)
                            - 25'd719469));
      epoch_in = 39'(days_ff) * 39'sd86400 + 39'(tod_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.push && len_ff < LEN_W'(TOKEN_BYTES))
         chars_ff[len_ff[IDX_W-1:0]] <= cmd.chr;
      if (cmd.calc1) begin
         y_ff   <= y_in;
         q_ff   <= q_in;
         doy_ff <= doy_in;
         tod_ff <= tod_in;
      end
      if (cmd.calc2)
         days_ff <= days_in;
      if (cmd.calc3)
         epoch_ff <= epoch_in;
      val_ff  <= val_in;
      alld_ff <= alld_in;
      if (cmd.load_out) begin
         out_ff.date_valid    <= !failed_ff && (phase_ff >= PH_ZONE);
         out_ff.epoch_seconds <= (!failed_ff && (phase_ff >= PH_ZONE)) ? epoch_ff : '1;
         out_ff.end_kind      <= cmd.end_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         len_ff     <= '0;
         phase_ff   <= PH_FIRST;
         day_ff     <= '0;
         month_ff   <= '0;
         year_ff    <= '0;
         hour_ff    <= '0;
         min_ff     <= '0;
         sec_ff     <= '0;
         zone_ff    <= '0;
         failed_ff  <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         phase_ff   <= phase_in;
         day_ff     <= day_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         hour_ff    <= hour_in;
         min_ff     <= min_in;
         sec_ff     <= sec_in;
         zone_ff    <= zone_in;
         failed_ff  <= failed_in;
         started_ff <= started_in;
      end
   end

   assign status.line_started = started_ff;
   assign rsp_data            = out_ff;

endmodule

[sv/mdep_controller.sv]
// ----------------------------------------------------------------------------
// mdep_controller
// line unfolding, event sequencing and handshake control
// ----------------------------------------------------------------------------
module mdep_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mdep_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mdep_pkg::cmd_type     cmd,
   input  mdep_pkg::status_type  status
);
   import mdep_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EV    = 3'd1;
   localparam logic [2:0] ST_CALC1 = 3'd2;
   localparam logic [2:0] ST_CALC2 = 3'd3;
   localparam logic [2:0] ST_CALC3 = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [1:0] U_IDLE  = 2'd0;
   localparam logic [1:0] U_CR    = 2'd1;
   localparam logic [1:0] U_EOL   = 2'd2;
   localparam logic [1:0] U_EOHCR = 2'd3;

   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_CHAR  = 3'd1;
   localparam logic [2:0] EV_BLANK = 3'd2;
   localparam logic [2:0] EV_EOL   = 3'd3;
   localparam logic [2:0] EV_EOH   = 3'd4;
   localparam logic [2:0] EV_EOF   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] u_ff, u_in;
   logic [2:0] ev0_ff, ev0_in, ev1_ff, ev1_in;
   logic [7:0] byte_ff;
   logic       slot_ff, slot_in;
   logic [1:0] kind_ff, kind_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept, to_idle, adv, eb;
   logic [2:0] cur, bev;
   logic [7:0] b;

   // unfold the incoming byte into at most two events
   always_comb begin
      b       = req_data.data_byte;
      eb      = (b == CH_SP) || (b == CH_TAB);
      bev     = eb ? EV_BLANK : EV_CHAR;
      ev0_in  = EV_NONE;
      ev1_in  = EV_NONE;
      u_in    = u_ff;
      to_idle = 1'b0;
      if (req_data.is_eof) begin
         if (u_ff == U_CR)
            ev0_in = EV_BLANK;
         else if (u_ff == U_EOL)
            ev0_in = EV_EOL;
         if (ev0_in == EV_NONE)
            ev0_in = EV_EOF;
         else
            ev1_in = EV_EOF;
         u_in = U_IDLE;
      end else begin
         case (u_ff)
            U_CR: begin
               if (b == CH_LF) u_in = U_EOL;
               else begin
                  ev0_in  = EV_BLANK;
                  to_idle = 1'b1;
               end
            end
            U_EOL: begin
               if (b == CH_CR) begin
                  ev0_in = EV_EOH;
                  u_in   = U_EOHCR;
               end else if (b == CH_LF) begin
                  ev0_in = EV_EOH;
                  u_in   = U_IDLE;
               end else if (eb) begin
                  ev0_in = EV_BLANK;
                  u_in   = U_IDLE;
               end else begin
                  ev0_in  = EV_EOL;
                  to_idle = 1'b1;
               end
            end
            U_EOHCR: begin
               u_in    = U_IDLE;
               to_idle = (b != CH_LF);
            end
            default: to_idle = 1'b1;
         endcase
         if (to_idle) begin
            if (b == CH_CR) u_in = U_CR;
            else if (b == CH_LF) u_in = U_EOL;
            else begin
               u_in = U_IDLE;
               if (ev0_in == EV_NONE) ev0_in = bev;
               else ev1_in = bev;
            end
         end
      end
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign cur       = slot_ff ? ev1_ff : ev0_ff;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      adv          = 1'b0;
      cmd          = '0;
      cmd.chr      = byte_ff;
      cmd.end_kind = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            slot_in = 1'b0;
            if (accept && ev0_in != EV_NONE) state_in = ST_EV;
         end
         ST_EV: begin
            case (cur)
               EV_CHAR: begin
                  cmd.push = 1'b1;
                  adv      = 1'b1;
               end
               EV_BLANK: begin
                  cmd.blank = 1'b1;
                  adv       = 1'b1;
               end
               default: begin
                  kind_in = (cur == EV_EOL) ? END_EOL :
                            (cur == EV_EOH) ? END_EOH : END_EOF;
                  // end of file on an empty line gives nothing
                  if (cur == EV_EOF && !status.line_started) adv = 1'b1;
                  else begin
                     cmd.close = 1'b1;
                     state_in  = ST_CALC1;
                  end
               end
            endcase
         end
         ST_CALC1: begin
            cmd.calc1 = 1'b1;
            state_in  = ST_CALC2;
         end
         ST_CALC2: begin
            cmd.calc2 = 1'b1;
            state_in  = ST_CALC3;
         end
         ST_CALC3: begin
            cmd.calc3 = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               adv          = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (adv) begin
         if (!slot_ff && ev1_ff != EV_NONE) begin
            slot_in  = 1'b1;
            state_in = ST_EV;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ev0_ff  <= ev0_in;
         ev1_ff  <= ev1_in;
         byte_ff <= b;
      end
      kind_ff <= kind_in;
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         u_ff         <= U_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) u_ff <= u_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
